/* rtl/core/fpts_pkg.sv */
// Shared types, constants and tables for the two-plant fuzzy priority scheduler.
package fpts_pkg;

    localparam int FRAC_BITS = 8;
    localparam int SUM_WIDTH = 32;
    localparam int Q_ONE     = 1 << FRAC_BITS;
    localparam int W_W       = FRAC_BITS + 1;
    localparam int NUM_W     = W_W + 5;
    localparam int QUO_W     = NUM_W + FRAC_BITS;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int SCALE_W   = 20;
    localparam int FQ_DEPTH  = 2;

    localparam logic [1:0] OP_ONE    = 2'd0;
    localparam logic [1:0] OP_TWO    = 2'd1;
    localparam logic [1:0] OP_SCAN   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] CASE_BAL  = 3'd0;
    localparam logic [2:0] CASE_ONE  = 3'd1;
    localparam logic [2:0] CASE_OONE = 3'd2;
    localparam logic [2:0] CASE_OTWO = 3'd3;
    localparam logic [2:0] CASE_NONE = 3'd4;

    localparam logic [2:0] REG_SP1 = 3'd0;
    localparam logic [2:0] REG_SP2 = 3'd1;
    localparam logic [2:0] REG_G1  = 3'd2;
    localparam logic [2:0] REG_G2  = 3'd3;
    localparam logic [2:0] REG_B1  = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic       negative;
        logic [7:0] magnitude;
    } item_t;

    typedef struct packed {
        logic        serve_plant;
        logic [2:0]  case_code;
        logic        record_valid;
        logic [15:0] error_one;
        logic [15:0] error_two;
        logic [15:0] speed_one;
        logic [15:0] speed_two;
        logic [10:0] priority_one;
        logic [10:0] priority_two;
        logic [31:0] abs_error_sum_one;
        logic [31:0] abs_error_sum_two;
    } result_t;

    function automatic logic [2:0] rule(input logic [2:0] c, input logic [2:0] e);
        logic [2:0] r;
        r = 3'd5;
        case ({c, e})
            {3'd0, 3'd2}: r = 3'd4;
            {3'd0, 3'd3}: r = 3'd1;
            {3'd1, 3'd1}: r = 3'd4;
            {3'd1, 3'd2}: r = 3'd3;
            {3'd1, 3'd3}: r = 3'd2;
            {3'd2, 3'd1}: r = 3'd3;
            {3'd2, 3'd2}: r = 3'd1;
            {3'd2, 3'd3}: r = 3'd3;
            {3'd3, 3'd1}: r = 3'd2;
            {3'd3, 3'd2}: r = 3'd3;
            {3'd3, 3'd3}: r = 3'd4;
            {3'd4, 3'd1}: r = 3'd1;
            {3'd4, 3'd2}: r = 3'd4;
            {3'd4, 3'd3}: r = 3'd5;
            default: r = 3'd5;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/fpts_front.sv */
// Front end: input queue that holds accepted items for the back end.
module fpts_front
    import fpts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t in_item,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_take
);
    item_t           mem_reg [FQ_DEPTH];
    logic            wr_reg, rd_reg;
    logic [1:0]      cnt_reg;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == 2'(FQ_DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wr_reg <= ~wr_reg;
            if (do_pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

/* rtl/core/fpts_div.sv */
// Restoring serial divider for the weighted average, one quotient bit per cycle.
module fpts_div
    import fpts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [W_W+1:0]   divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);
    logic [QUO_W-1:0] q_reg, q_next;
    logic [W_W+2:0]   r_reg, r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg;
    logic [W_W+2:0]   trial;

    assign quotient = q_reg;
    assign done     = done_reg;
    assign trial    = {r_reg[W_W+1:0], q_reg[QUO_W-1]};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end
endmodule

/* rtl/core/fpts_back.sv */
// Back end: sample scaling, fuzzy inference, plant state and scan results.
module fpts_back
    import fpts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  item_t        q_item,
    output logic         q_take,
    input  logic [15:0]  setpoint_one,
    input  logic [15:0]  setpoint_two,
    input  logic [15:0]  speed_gain_one,
    input  logic [15:0]  speed_gain_two,
    input  logic [7:0]   priority_bias_one,
    output logic         res_valid,
    output result_t      res,
    input  logic         res_take
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_ERR   = 7'b0000100,
        ST_MEM   = 7'b0001000,
        ST_NUM   = 7'b0010000,
        ST_GO    = 7'b0100000,
        ST_DIV   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] lerr1_reg, lerr2_reg, spd1_reg, spd2_reg;
    logic [10:0]        pri1_reg, pri2_reg;
    logic               pend1_reg, pend2_reg;
    logic [SUM_WIDTH-1:0] sum1_reg, sum2_reg;
    logic               res_valid_reg;
    result_t            res_reg;

    logic               plant_reg;
    logic               neg_reg;
    logic [23:0]        prod_reg;
    logic signed [15:0] spd_reg, err_reg;
    logic signed [16:0] chg_reg;
    logic [W_W-1:0]     e0_reg, c0_reg;
    logic [1:0]         ei_reg, ci_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [W_W+1:0]     den_reg;

    logic [7:0]  mag;
    logic [15:0] gain;
    logic [24:0] rnd;
    logic [16:0] m;
    logic signed [17:0] spd_w, err_w;
    logic signed [15:0] spd_s, err_s;
    logic signed [15:0] setp, lerr;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) return 16'sh7FFF;
        if (v < -18'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [SCALE_W-1:0] clampq(input logic signed [SCALE_W-1:0] v);
        logic signed [SCALE_W-1:0] lim;
        lim = SCALE_W'(8 * Q_ONE);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic [W_W+1:0] member(input logic signed [SCALE_W-1:0] x,
                                              output logic [1:0] reg_o);
        logic signed [SCALE_W-1:0] two, four, t;
        two  = SCALE_W'(2 * Q_ONE);
        four = SCALE_W'(4 * Q_ONE);
        if (x < -two)
        begin
            t = (x < -four) ? -four : x;
            reg_o = 2'd0;
            t = -t - two;
        end
        else if (x < 0)
        begin
            reg_o = 2'd1;
            t = -x;
        end
        else if (x < two)
        begin
            reg_o = 2'd2;
            t = two - x;
        end
        else
        begin
            t = (x > four) ? four : x;
            reg_o = 2'd3;
            t = four - t;
        end
        return (W_W+2)'(t >>> 1);
    endfunction

    logic signed [SCALE_W-1:0] es, cs;
    logic [1:0]     ei_w, ci_w;
    logic [W_W+1:0] e0_w, c0_w;
    logic [W_W-1:0] e1, c1, w0, w1, w2, w3;
    logic [NUM_W-1:0] num_w;
    logic [W_W+1:0] den_w;

    logic           div_start, div_done;
    logic [QUO_W-1:0] div_q;
    logic [QUO_W-1:0] dividend;
    logic [QUO_W:0] pri_w;
    logic [10:0]    pri_sat;
    logic [15:0]    abs_err;
    logic [SUM_WIDTH:0] sum_add;
    logic [SUM_WIDTH-1:0] sum_cur, sum_new;

    logic           scan_go;
    result_t        scan_res;

    assign mag   = q_item.magnitude;
    assign gain  = q_item.op[0] ? speed_gain_two : speed_gain_one;
    assign setp  = plant_reg ? setpoint_two : setpoint_one;
    assign lerr  = plant_reg ? lerr2_reg : lerr1_reg;
    assign rnd   = {1'b0, prod_reg} + 25'(1 << (15 - FRAC_BITS));
    assign m     = 17'(rnd >> (16 - FRAC_BITS));
    assign spd_w = neg_reg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    assign spd_s = sat16(spd_w);
    assign err_w = 18'(spd_reg) - 18'(setp);
    assign err_s = sat16(err_w);

    assign es   = clampq(SCALE_W'(err_reg) <<< 3);
    assign cs   = clampq(SCALE_W'(chg_reg) <<< 2);

    always_comb
    begin
        e0_w = member(es, ei_w);
        c0_w = member(cs, ci_w);
    end

    assign e1 = W_W'(Q_ONE) - e0_reg;
    assign c1 = W_W'(Q_ONE) - c0_reg;
    assign w0 = (e0_reg < c0_reg) ? e0_reg : c0_reg;
    assign w1 = (e0_reg < c1) ? e0_reg : c1;
    assign w2 = (e1 < c0_reg) ? e1 : c0_reg;
    assign w3 = (e1 < c1) ? e1 : c1;
    assign num_w = NUM_W'(rule({1'b0, ci_reg}, {1'b0, ei_reg})) * NUM_W'(w0)
                 + NUM_W'(rule({1'b0, ci_reg} + 3'd1, {1'b0, ei_reg})) * NUM_W'(w1)
                 + NUM_W'(rule({1'b0, ci_reg}, {1'b0, ei_reg} + 3'd1)) * NUM_W'(w2)
                 + NUM_W'(rule({1'b0, ci_reg} + 3'd1, {1'b0, ei_reg} + 3'd1)) * NUM_W'(w3);
    assign den_w = (W_W+2)'(w0) + (W_W+2)'(w1) + (W_W+2)'(w2) + (W_W+2)'(w3);

    assign dividend  = (QUO_W'(num_reg) << FRAC_BITS) + QUO_W'(den_reg >> 1);
    assign div_start = (state_reg == ST_GO) && (den_reg != '0);

    fpts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign pri_w   = {1'b0, ((den_reg == '0) ? QUO_W'(0) : div_q)}
                   + (plant_reg ? (QUO_W+1)'(0)
                                : (QUO_W+1)'((32'(priority_bias_one) * Q_ONE) >> 8));
    assign pri_sat = (pri_w > (QUO_W+1)'(2047)) ? 11'd2047 : 11'(pri_w);
    assign abs_err = err_reg[15] ? 16'(-err_reg) : 16'(err_reg);
    assign sum_cur = plant_reg ? sum2_reg : sum1_reg;
    assign sum_add = {1'b0, sum_cur} + (SUM_WIDTH+1)'(abs_err);
    assign sum_new = sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];

    assign scan_go = (state_reg == ST_IDLE) && q_valid && (q_item.op == OP_SCAN)
                  && (!res_valid_reg || res_take);
    assign q_take  = (state_reg == ST_IDLE) && q_valid
                  && ((q_item.op != OP_SCAN) || scan_go);

    function automatic logic [31:0] sum32(input logic [SUM_WIDTH-1:0] s);
        logic [63:0] w;
        w = 64'(s);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    always_comb
    begin
        scan_res.serve_plant  = 1'b1;
        scan_res.case_code    = CASE_NONE;
        scan_res.record_valid = pend1_reg || pend2_reg;
        if (pend1_reg && pend2_reg)
        begin
            scan_res.serve_plant = (pri1_reg < pri2_reg);
            scan_res.case_code   = (pri1_reg < pri2_reg) ? CASE_BAL : CASE_ONE;
        end
        else if (pend1_reg)
        begin
            scan_res.serve_plant = 1'b0;
            scan_res.case_code   = CASE_OONE;
        end
        else if (pend2_reg)
        begin
            scan_res.case_code = CASE_OTWO;
        end
        scan_res.error_one         = lerr1_reg;
        scan_res.error_two         = lerr2_reg;
        scan_res.speed_one         = spd1_reg;
        scan_res.speed_two         = spd2_reg;
        scan_res.priority_one      = pri1_reg;
        scan_res.priority_two      = pri2_reg;
        scan_res.abs_error_sum_one = sum32(sum1_reg);
        scan_res.abs_error_sum_two = sum32(sum2_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_take && (q_item.op == OP_ONE || q_item.op == OP_TWO))
                         state_next = ST_MUL;
            ST_MUL:  state_next = ST_ERR;
            ST_ERR:  state_next = ST_MEM;
            ST_MEM:  state_next = ST_NUM;
            ST_NUM:  state_next = ST_GO;
            ST_GO:   state_next = (den_reg == '0) ? ST_IDLE : ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic finish;
    assign finish = ((state_reg == ST_GO) && (den_reg == '0))
                 || ((state_reg == ST_DIV) && div_done);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                plant_reg <= q_item.op[0];
                neg_reg   <= q_item.negative;
                prod_reg  <= 24'(mag) * 24'(gain);
            end
            ST_MUL: spd_reg <= spd_s;
            ST_ERR:
            begin
                err_reg <= err_s;
                chg_reg <= 17'(err_s) - 17'(lerr);
            end
            ST_MEM:
            begin
                e0_reg <= W_W'(e0_w);
                c0_reg <= W_W'(c0_w);
                ei_reg <= ei_w;
                ci_reg <= ci_w;
            end
            ST_NUM:
            begin
                num_reg <= num_w;
                den_reg <= den_w;
            end
            default:
            begin
            end
        endcase
        if (scan_go) res_reg <= scan_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lerr1_reg     <= '0;
            lerr2_reg     <= '0;
            spd1_reg      <= '0;
            spd2_reg      <= '0;
            pri1_reg      <= '0;
            pri2_reg      <= '0;
            pend1_reg     <= 1'b0;
            pend2_reg     <= 1'b0;
            sum1_reg      <= '0;
            sum2_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                if (plant_reg)
                begin
                    spd2_reg  <= spd_reg;
                    lerr2_reg <= err_reg;
                    pri2_reg  <= pri_sat;
                    sum2_reg  <= sum_new;
                    pend2_reg <= 1'b1;
                end
                else
                begin
                    spd1_reg  <= spd_reg;
                    lerr1_reg <= err_reg;
                    pri1_reg  <= pri_sat;
                    sum1_reg  <= sum_new;
                    pend1_reg <= 1'b1;
                end
            end
            if (scan_go)
            begin
                pend1_reg     <= 1'b0;
                pend2_reg     <= 1'b0;
                res_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
endmodule

/* rtl/core/fuzzy_priority_two_plant_scheduler_unit.sv */
// Top level of the two-plant fuzzy priority scheduler.
//  channel   dir   handshake       payload
//  input     in    push / full     op, negative, magnitude
//  result    out   empty / pop     serve_plant ... abs_error_sum_two
//  config    in    cfg_we          cfg_index, cfg_data
// A sample keeps the back end busy after its transfer: scaling, error, membership and
// rule sums, then the serial weighted-average divider unless the weights sum to zero.
// A scan tick is taken once the back end is idle and the result register is free.
// Reset is asynchronous and clears all plant state; no clearing pass.
// A held result stalls a queued scan and every item behind it in the queue.
module fuzzy_priority_two_plant_scheduler_unit
    import fpts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic        negative,
    input  logic [7:0]  magnitude,
    output logic        empty,
    input  logic        pop,
    output logic        serve_plant,
    output logic [2:0]  case_code,
    output logic        record_valid,
    output logic [15:0] error_one,
    output logic [15:0] error_two,
    output logic [15:0] speed_one,
    output logic [15:0] speed_two,
    output logic [10:0] priority_one,
    output logic [10:0] priority_two,
    output logic [31:0] abs_error_sum_one,
    output logic [31:0] abs_error_sum_two,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [15:0] sp1_reg, sp2_reg, g1_reg, g2_reg;
    logic [7:0]  b1_reg;
    item_t       in_item, q_item;
    logic        q_valid, q_take, res_valid;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp1_reg <= '0;
            sp2_reg <= '0;
            g1_reg  <= 16'd1736;
            g2_reg  <= 16'd868;
            b1_reg  <= 8'd26;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SP1: sp1_reg <= cfg_data;
                REG_SP2: sp2_reg <= cfg_data;
                REG_G1:  g1_reg  <= cfg_data;
                REG_G2:  g2_reg  <= cfg_data;
                REG_B1:  b1_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign in_item = '{op: op, negative: negative, magnitude: magnitude};

    fpts_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    fpts_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_take            (q_take),
        .setpoint_one      (sp1_reg),
        .setpoint_two      (sp2_reg),
        .speed_gain_one    (g1_reg),
        .speed_gain_two    (g2_reg),
        .priority_bias_one (b1_reg),
        .res_valid         (res_valid),
        .res               (res),
        .res_take          (pop)
    );

    assign empty             = !res_valid;
    assign serve_plant       = res.serve_plant;
    assign case_code         = res.case_code;
    assign record_valid      = res.record_valid;
    assign error_one         = res.error_one;
    assign error_two         = res.error_two;
    assign speed_one         = res.speed_one;
    assign speed_two         = res.speed_two;
    assign priority_one      = res.priority_one;
    assign priority_two      = res.priority_two;
    assign abs_error_sum_one = res.abs_error_sum_one;
    assign abs_error_sum_two = res.abs_error_sum_two;

    a_no_valid_none: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (case_code == CASE_NONE) |-> !record_valid)
        else $error("none case flagged valid");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(case_code))
        else $error("result changed while held");
    a_serve_case: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (case_code == CASE_OONE) |-> !serve_plant)
        else $error("plant one only case serves plant two");
endmodule

/* verif/fuzzy_priority_two_plant_scheduler_unit_tb.sv */
// Self-checking bench for the two-plant fuzzy priority scheduler: directed table plus random traffic.
`timescale 1ns / 100ps

module fuzzy_priority_two_plant_scheduler_unit_tb;
    import fpts_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  op;
    logic        negative;
    logic [7:0]  magnitude;
    logic        empty;
    logic        pop;
    logic        serve_plant;
    logic [2:0]  case_code;
    logic        record_valid;
    logic [15:0] error_one;
    logic [15:0] error_two;
    logic [15:0] speed_one;
    logic [15:0] speed_two;
    logic [10:0] priority_one;
    logic [10:0] priority_two;
    logic [31:0] abs_error_sum_one;
    logic [31:0] abs_error_sum_two;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    fuzzy_priority_two_plant_scheduler_unit dut (.*);

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 128;

    typedef struct {
        logic [1:0] op;
        logic       neg;
        logic [7:0] mag;
        logic       typed;
        result_t    res;
    } row_t;

    logic signed [15:0] sp1, sp2;
    logic [15:0]        gain1, gain2;
    logic [7:0]         bias1;
    logic signed [15:0] lerr1, lerr2, spd1, spd2;
    logic [10:0]        pri1, pri2;
    logic               pend1, pend2;
    logic [31:0]        sum1, sum2;

    result_t scan_queue[$];
    int      failures;
    int      cycles;
    int      scans_seen;
    int      items_sent;
    bit      hold_pop;
    bit      calm;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int memb(input int x, output int region);
        if (x < -2 * Q_ONE)
        begin
            if (x < -4 * Q_ONE)
                x = -4 * Q_ONE;
            region = 0;
            return (-x - 2 * Q_ONE) >>> 1;
        end
        if (x < 0)
        begin
            region = 1;
            return (-x) >>> 1;
        end
        if (x < 2 * Q_ONE)
        begin
            region = 2;
            return (2 * Q_ONE - x) >>> 1;
        end
        if (x > 4 * Q_ONE)
            x = 4 * Q_ONE;
        region = 3;
        return (4 * Q_ONE - x) >>> 1;
    endfunction

    function automatic int rulev(input int c, input int e);
        int tab[5][5];
        tab = '{'{5, 5, 4, 1, 5}, '{5, 4, 3, 2, 5}, '{5, 3, 1, 3, 5},
                '{5, 2, 3, 4, 5}, '{5, 1, 4, 5, 5}};
        return tab[c][e];
    endfunction

    function automatic int imin(input int a, input int b);
        return a < b ? a : b;
    endfunction

    function automatic longint fuzzy_priority(input int err, input int chg);
        longint es, cs, num, den;
        int ei, ci, e0, c0, e1, c1, w0, w1, w2, w3;
        es = longint'(err) * 8;
        cs = longint'(chg) * 4;
        if (es > 8 * Q_ONE) es = 8 * Q_ONE;
        if (es < -8 * Q_ONE) es = -8 * Q_ONE;
        if (cs > 8 * Q_ONE) cs = 8 * Q_ONE;
        if (cs < -8 * Q_ONE) cs = -8 * Q_ONE;
        e0 = memb(int'(es), ei);
        c0 = memb(int'(cs), ci);
        e1 = Q_ONE - e0;
        c1 = Q_ONE - c0;
        w0 = imin(e0, c0);
        w1 = imin(e0, c1);
        w2 = imin(e1, c0);
        w3 = imin(e1, c1);
        num = rulev(ci, ei) * w0 + rulev(ci + 1, ei) * w1
            + rulev(ci, ei + 1) * w2 + rulev(ci + 1, ei + 1) * w3;
        den = w0 + w1 + w2 + w3;
        if (den == 0)
            return 0;
        return (num * Q_ONE + den / 2) / den;
    endfunction

    task automatic plant_sample(input logic neg, input logic [7:0] mag, input logic [15:0] gain,
                                input logic signed [15:0] setp, input logic [7:0] bias,
                                inout logic signed [15:0] spd, inout logic signed [15:0] lerr,
                                inout logic [10:0] pri, inout logic [31:0] sum,
                                inout logic pend);
        longint m, speed, err, p, a, s;
        m = (longint'(mag) * gain + (1 << (15 - FRAC_BITS))) >>> (16 - FRAC_BITS);
        speed = neg ? -m : m;
        if (speed > 32767) speed = 32767;
        if (speed < -32768) speed = -32768;
        err = speed - setp;
        if (err > 32767) err = 32767;
        if (err < -32768) err = -32768;
        p = fuzzy_priority(int'(err), int'(err - lerr)) + ((longint'(bias) * Q_ONE) >>> 8);
        a = err < 0 ? -err : err;
        s = longint'(sum) + a;
        spd = speed[15:0];
        lerr = err[15:0];
        pri = p > 2047 ? 11'd2047 : p[10:0];
        sum = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
        pend = 1'b1;
    endtask

    task automatic predict_item(input logic [1:0] iop, input logic neg, input logic [7:0] mag);
        result_t r;
        if (iop == OP_ONE)
            plant_sample(neg, mag, gain1, sp1, bias1, spd1, lerr1, pri1, sum1, pend1);
        else if (iop == OP_TWO)
            plant_sample(neg, mag, gain2, sp2, 8'd0, spd2, lerr2, pri2, sum2, pend2);
        else if (iop == OP_SCAN)
        begin
            r.record_valid = 1'b1;
            if (pend1 && pend2)
            begin
                if (pri1 < pri2)
                begin
                    r.case_code = CASE_BAL;
                    r.serve_plant = 1'b1;
                end
                else
                begin
                    r.case_code = CASE_ONE;
                    r.serve_plant = 1'b0;
                end
                pend1 = 1'b0;
                pend2 = 1'b0;
            end
            else if (pend1)
            begin
                r.case_code = CASE_OONE;
                r.serve_plant = 1'b0;
                pend1 = 1'b0;
            end
            else if (pend2)
            begin
                r.case_code = CASE_OTWO;
                r.serve_plant = 1'b1;
                pend2 = 1'b0;
            end
            else
            begin
                r.case_code = CASE_NONE;
                r.serve_plant = 1'b1;
                r.record_valid = 1'b0;
            end
            r.error_one = lerr1;
            r.error_two = lerr2;
            r.speed_one = spd1;
            r.speed_two = spd2;
            r.priority_one = pri1;
            r.priority_two = pri2;
            r.abs_error_sum_one = sum1;
            r.abs_error_sum_two = sum2;
            scan_queue.push_back(r);
        end
    endtask

    task automatic send_item(input logic [1:0] iop, input logic neg, input logic [7:0] mag);
        while (!calm && $urandom_range(99) < 21)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        op <= iop;
        negative <= neg;
        magnitude <= mag;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(iop, neg, mag);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SP1: sp1 = val;
            REG_SP2: sp2 = val;
            REG_G1:  gain1 = val;
            REG_G2:  gain2 = val;
            REG_B1:  bias1 = val[7:0];
            default: ;
        endcase
    endtask

    task automatic settle;
        push <= 1'b0;
        while (scan_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic random_item(input int flavor);
        int k;
        k = $urandom_range(99);
        if (k < 3)
            send_item(OP_UNUSED, 1'($urandom_range(1)), 8'($urandom_range(255)));
        else if (k < 30)
            send_item(OP_SCAN, 1'($urandom_range(1)), 8'($urandom_range(255)));
        else if (flavor == 0)
            send_item(k < 65 ? OP_ONE : OP_TWO, 1'($urandom_range(1)),
                      8'($urandom_range(255)));
        else
            send_item(k < 65 ? OP_ONE : OP_TWO, 1'($urandom_range(1)),
                      8'($urandom_range(1) ? $urandom_range(255) : $urandom_range(24)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            pop <= !hold_pop && (calm || $urandom_range(99) >= 21);
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && pop && !empty)
        begin
            scans_seen++;
            if (scan_queue.size() == 0)
            begin
                $error("unexpected result transfer");
                failures++;
            end
            else
            begin
                exp_r = scan_queue.pop_front();
                if (serve_plant !== exp_r.serve_plant)
                begin
                    $error("serve_plant exp %0h got %0h", exp_r.serve_plant, serve_plant);
                    failures++;
                end
                if (case_code !== exp_r.case_code)
                begin
                    $error("case_code exp %0h got %0h", exp_r.case_code, case_code);
                    failures++;
                end
                if (record_valid !== exp_r.record_valid)
                begin
                    $error("record_valid exp %0h got %0h", exp_r.record_valid, record_valid);
                    failures++;
                end
                if (error_one !== exp_r.error_one)
                begin
                    $error("error_one exp %0h got %0h", exp_r.error_one, error_one);
                    failures++;
                end
                if (error_two !== exp_r.error_two)
                begin
                    $error("error_two exp %0h got %0h", exp_r.error_two, error_two);
                    failures++;
                end
                if (speed_one !== exp_r.speed_one)
                begin
                    $error("speed_one exp %0h got %0h", exp_r.speed_one, speed_one);
                    failures++;
                end
                if (speed_two !== exp_r.speed_two)
                begin
                    $error("speed_two exp %0h got %0h", exp_r.speed_two, speed_two);
                    failures++;
                end
                if (priority_one !== exp_r.priority_one)
                begin
                    $error("priority_one exp %0h got %0h", exp_r.priority_one, priority_one);
                    failures++;
                end
                if (priority_two !== exp_r.priority_two)
                begin
                    $error("priority_two exp %0h got %0h", exp_r.priority_two, priority_two);
                    failures++;
                end
                if (abs_error_sum_one !== exp_r.abs_error_sum_one)
                begin
                    $error("abs_error_sum_one exp %0h got %0h", exp_r.abs_error_sum_one,
                           abs_error_sum_one);
                    failures++;
                end
                if (abs_error_sum_two !== exp_r.abs_error_sum_two)
                begin
                    $error("abs_error_sum_two exp %0h got %0h", exp_r.abs_error_sum_two,
                           abs_error_sum_two);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fuzzy_priority_two_plant_scheduler_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        result_t zero_res;
        int pass_no;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        op = OP_ONE;
        negative = 1'b0;
        magnitude = 8'd0;
        cfg_we = 1'b0;
        cfg_index = REG_SP1;
        cfg_data = 16'd0;
        failures = 0;
        cycles = 0;
        scans_seen = 0;
        items_sent = 0;
        hold_pop = 1'b0;
        calm = 1'b0;
        sp1 = 0; sp2 = 0; gain1 = 16'd1736; gain2 = 16'd868; bias1 = 8'd26;
        lerr1 = 0; lerr2 = 0; spd1 = 0; spd2 = 0; pri1 = 0; pri2 = 0;
        pend1 = 0; pend2 = 0; sum1 = 0; sum2 = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        zero_res = '0;
        zero_res.case_code = CASE_NONE;
        zero_res.serve_plant = 1'b1;
        rows.push_back('{OP_SCAN, 1'b0, 8'd0, 1'b1, zero_res});
        rows.push_back('{OP_ONE, 1'b0, 8'd255, 1'b0, zero_res});
        rows.push_back('{OP_SCAN, 1'b0, 8'd0, 1'b0, zero_res});
        rows.push_back('{OP_TWO, 1'b1, 8'd255, 1'b0, zero_res});
        rows.push_back('{OP_SCAN, 1'b1, 8'd0, 1'b0, zero_res});
        rows.push_back('{OP_ONE, 1'b1, 8'd0, 1'b0, zero_res});
        rows.push_back('{OP_TWO, 1'b0, 8'd0, 1'b0, zero_res});
        rows.push_back('{OP_SCAN, 1'b0, 8'd0, 1'b0, zero_res});
        rows.push_back('{OP_ONE, 1'b0, 8'd7, 1'b0, zero_res});
        rows.push_back('{OP_TWO, 1'b0, 8'd200, 1'b0, zero_res});
        rows.push_back('{OP_UNUSED, 1'b1, 8'd255, 1'b0, zero_res});
        rows.push_back('{OP_SCAN, 1'b0, 8'd0, 1'b0, zero_res});
        rows.push_back('{OP_ONE, 1'b1, 8'd128, 1'b0, zero_res});
        rows.push_back('{OP_ONE, 1'b0, 8'd128, 1'b0, zero_res});
        rows.push_back('{OP_TWO, 1'b1, 8'd1, 1'b0, zero_res});
        rows.push_back('{OP_SCAN, 1'b0, 8'd0, 1'b0, zero_res});
        rows.push_back('{OP_SCAN, 1'b0, 8'd0, 1'b0, zero_res});

        foreach (rows[i])
        begin
            rw = rows[i];
            send_item(rw.op, rw.neg, rw.mag);
            if (rw.typed)
            begin
                void'(scan_queue.pop_back());
                scan_queue.push_back(rw.res);
            end
        end
        settle();

        write_reg(REG_SP1, 16'h7FFF);
        write_reg(REG_SP2, 16'h8000);
        write_reg(REG_G1, 16'hFFFF);
        write_reg(REG_G2, 16'h0000);
        write_reg(REG_B1, 16'h00FF);
        repeat (12)
            send_item(OP_ONE, 1'($urandom_range(1)), 8'd255);
        repeat (6)
            send_item(OP_TWO, 1'($urandom_range(1)), 8'($urandom_range(255)));
        send_item(OP_SCAN, 1'b0, 8'd0);
        settle();

        for (pass_no = 0; pass_no < 4; pass_no++)
        begin
            write_reg(REG_SP1,
                      16'($urandom_range(1) ? $urandom_range(65535) : $urandom_range(2048)));
            write_reg(REG_SP2, 16'($urandom_range(65535)));
            write_reg(REG_G1, pass_no == 3 ? 16'd0 : 16'($urandom_range(65535)));
            write_reg(REG_G2, pass_no == 1 ? 16'hFFFF : 16'($urandom_range(4000)));
            write_reg(REG_B1, pass_no == 2 ? 16'd0 : 16'($urandom_range(255)));
            calm = (pass_no == 1);
            if (pass_no == 2)
            begin
                fork
                    begin
                        hold_pop = 1'b1;
                        repeat (3000)
                            @(posedge clk);
                        hold_pop = 1'b0;
                    end
                    repeat (60)
                        send_item(OP_SCAN, 1'b0, 8'd0);
                join
            end
            repeat (190)
                random_item(pass_no & 1);
            calm = 1'b0;
            settle();
        end

        write_reg(REG_SP1, 16'd0);
        write_reg(REG_SP2, 16'd0);
        write_reg(REG_G1, 16'd1736);
        write_reg(REG_G2, 16'd868);
        write_reg(REG_B1, 16'd26);
        repeat (20)
            random_item(1);
        settle();

        $display("covered %0d transfers in, %0d scan results out, across six register settings",
                 items_sent, scans_seen);
        if (failures == 0)
            $display("fuzzy_priority_two_plant_scheduler_unit: match");
        else
            $display("fuzzy_priority_two_plant_scheduler_unit: mismatch");
        $finish;
    end
endmodule
